### hdl/command_frame_parameter_decoder_assert.svh
`ifndef COMMAND_FRAME_PARAMETER_DECODER_ASSERT_SVH
`define COMMAND_FRAME_PARAMETER_DECODER_ASSERT_SVH

// same-cycle implication
`define CFPD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfpd assertion failed");

// next-cycle implication
`define CFPD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfpd assertion failed");

`endif

### hdl/cfpd_pkg.sv
package cfpd_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 24;
  localparam int RUN_LEN = 4;
  localparam int ZRUN_W  = 3;

  localparam logic [ZRUN_W-1:0] ZRUN_SAT  = ZRUN_W'(RUN_LEN);
  localparam logic [ZRUN_W-1:0] ZRUN_TRIG = ZRUN_W'(RUN_LEN - 1);

  localparam logic [VALUE_W-1:0] ERR_BAD_LEN = VALUE_W'(0);
  localparam logic [VALUE_W-1:0] ERR_TRUNC   = VALUE_W'(1);

  typedef enum logic [1:0] {
    KIND_VERSION = 2'd0,
    KIND_COMMAND = 2'd1,
    KIND_PARAM   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VER,
    ST_CMD,
    ST_LEN,
    ST_VAL,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    kind_e               kind;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } result_t;

endpackage

### hdl/cfpd_buf.sv
module cfpd_buf
  import cfpd_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [2**AW];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cfpd_fifo.sv
module cfpd_fifo
  import cfpd_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  input  logic         pop_i,
  output logic [W-1:0] dout_o,
  output logic         full_o,
  output logic         empty_o,
  output logic         wr_bank_o,
  output logic         rd_bank_o
);

  localparam logic [1:0] Entries = 2'd2;

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= din_i;
    end
  end

  assign dout_o    = slot_q[rd_ptr_q];
  assign full_o    = (count_q == Entries);
  assign empty_o   = (count_q == 2'd0);
  assign wr_bank_o = wr_ptr_q;
  assign rd_bank_o = rd_ptr_q;

endmodule

### hdl/cfpd_front.sv
module cfpd_front
  import cfpd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            byte_valid_i,
  output logic                            byte_ready_o,
  input  logic [BYTE_W-1:0]               byte_i,
  input  logic                            burst_end_i,
  input  logic                            full_i,
  output logic                            mem_we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] mem_waddr_o,
  output logic [BYTE_W-1:0]               mem_wdata_o,
  output logic                            push_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] push_len_o,
  output logic                            push_has_cmd_o
);

  localparam int PosW = $clog2(BUFFER_DEPTH);
  localparam int CntW = PosW + 1;
  localparam logic [CntW-1:0] Depth    = CntW'(BUFFER_DEPTH);
  localparam logic [CntW-1:0] Limit    = CntW'(BUFFER_DEPTH - RUN_LEN);
  localparam logic [CntW-1:0] RunBack  = CntW'(RUN_LEN - 1);
  localparam logic [CntW-1:0] CmdCount = CntW'(2);

  logic [CntW-1:0]   cnt_q, cnt_d, cnt_n;
  logic [ZRUN_W-1:0] zrun_q, zrun_d, zrun_n;
  logic              found_q, found_d, found_n;
  logic [CntW-1:0]   fpos_q, fpos_d, fpos_n;
  logic [CntW-1:0]   start;
  logic [CntW-1:0]   len;
  logic              room;
  logic              accept;

  assign accept = byte_valid_i && !full_i;
  assign room   = (cnt_q < Depth);

  always_comb begin
    cnt_n   = cnt_q;
    zrun_n  = zrun_q;
    found_n = found_q;
    fpos_n  = fpos_q;
    if (room) begin
      cnt_n = cnt_q + CntW'(1);
      if (byte_i == '0) begin
        if (zrun_q != ZRUN_SAT) begin
          zrun_n = zrun_q + ZRUN_W'(1);
        end
        if (zrun_q == ZRUN_TRIG && !found_q && (cnt_q - RunBack) < Limit) begin
          found_n = 1'b1;
          fpos_n  = cnt_q - RunBack;
        end
      end else begin
        zrun_n = '0;
      end
    end

    start = cnt_n - CntW'(zrun_n);
    if (found_n) begin
      len = fpos_n;
    end else if (start < Limit) begin
      len = start;
    end else begin
      len = Limit;
    end

    cnt_d   = cnt_q;
    zrun_d  = zrun_q;
    found_d = found_q;
    fpos_d  = fpos_q;
    if (accept) begin
      if (burst_end_i) begin
        cnt_d   = '0;
        zrun_d  = '0;
        found_d = 1'b0;
      end else begin
        cnt_d   = cnt_n;
        zrun_d  = zrun_n;
        found_d = found_n;
        fpos_d  = fpos_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      zrun_q  <= '0;
      found_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      zrun_q  <= zrun_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fpos_q <= fpos_d;
  end

  assign byte_ready_o   = !full_i;
  assign mem_we_o       = accept && room;
  assign mem_waddr_o    = cnt_q[PosW-1:0];
  assign mem_wdata_o    = byte_i;
  assign push_o         = accept && burst_end_i;
  assign push_len_o     = len[PosW-1:0];
  assign push_has_cmd_o = (cnt_n >= CmdCount);

endmodule

### hdl/cfpd_back.sv
module cfpd_back
  import cfpd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            desc_valid_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] len_i,
  input  logic                            has_cmd_i,
  input  logic [BYTE_W-1:0]               rdata_i,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rpos_o,
  output logic                            pop_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output result_t                         res_o
);

  localparam int PosW = $clog2(BUFFER_DEPTH);
  localparam logic [PosW-1:0] PosCmd   = PosW'(1);
  localparam logic [PosW-1:0] PosFirst = PosW'(2);

  back_state_e        state_q, state_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               res_valid_q;
  result_t            res_q, res_n;
  logic               emit;
  logic               pop;
  logic               out_free;
  logic               bad;
  logic               trunc;
  logic [PosW:0]      end_pos;

  assign out_free = !res_valid_q || res_ready_i;
  assign bad      = (rdata_i[BYTE_W-1:2] != '0) || (rdata_i[1:0] == 2'd0);
  assign end_pos  = {1'b0, pos_q} + (PosW + 1)'(rdata_i[1:0]);
  assign trunc    = (end_pos >= {1'b0, len_i});

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    pop     = 1'b0;
    res_n   = '{kind: KIND_VERSION, value: '0, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (desc_valid_i) begin
          pos_d   = '0;
          state_d = ST_VER;
        end
      end
      ST_VER: begin
        if (out_free) begin
          emit    = 1'b1;
          res_n   = '{kind: KIND_VERSION, value: VALUE_W'(rdata_i), last: 1'b0};
          pos_d   = PosCmd;
          state_d = ST_CMD;
        end
      end
      ST_CMD: begin
        if (out_free) begin
          emit       = 1'b1;
          res_n.kind = KIND_COMMAND;
          res_n.value = has_cmd_i ? VALUE_W'(rdata_i) : '0;
          res_n.last = (len_i <= PosFirst);
          if (len_i <= PosFirst) begin
            pop     = 1'b1;
            pos_d   = '0;
            state_d = ST_IDLE;
          end else begin
            pos_d   = PosFirst;
            state_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (bad || trunc) begin
          if (out_free) begin
            emit    = 1'b1;
            res_n   = '{kind: KIND_ERROR, value: bad ? ERR_BAD_LEN : ERR_TRUNC, last: 1'b1};
            pop     = 1'b1;
            pos_d   = '0;
            state_d = ST_IDLE;
          end
        end else begin
          cnt_d   = rdata_i[1:0];
          acc_d   = '0;
          pos_d   = pos_q + PosW'(1);
          state_d = ST_VAL;
        end
      end
      ST_VAL: begin
        acc_d = {acc_q[VALUE_W-BYTE_W-1:0], rdata_i};
        cnt_d = cnt_q - 2'd1;
        pos_d = pos_q + PosW'(1);
        if (cnt_q == 2'd1) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit  = 1'b1;
          res_n = '{kind: KIND_PARAM, value: acc_q, last: (pos_q >= len_i)};
          if (pos_q >= len_i) begin
            pop     = 1'b1;
            pos_d   = '0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_LEN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    if (emit) begin
      res_q <= res_n;
    end
  end

  assign rpos_o      = pos_d;
  assign pop_o       = pop;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hdl/command_frame_parameter_decoder.sv
// bytes are taken one per cycle while fewer than two frames are queued for decoding (two buffer banks)
// the first result, the version, is registered after the frame is queued and its byte is read back
// version and command give one result each; a parameter reads its length byte, then n value bytes,
// then emits, through the single read port of the frame buffer walked by the decode sequencer
// reset clears the front-end counters, queue and sequencer state at once; buffer contents are left undefined
module command_frame_parameter_decoder
  import cfpd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tlast_i,   // burst_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [23:0]  m_axis_tdata_o,   // value
  output logic [1:0]   m_axis_tuser_o,   // kind
  output logic         m_axis_tlast_o    // last
);

  `include "command_frame_parameter_decoder_assert.svh"

  localparam int PosW = $clog2(BUFFER_DEPTH);
  localparam int AddrW = PosW + 1;
  localparam logic [PosW-1:0] Limit = PosW'(BUFFER_DEPTH - RUN_LEN);

  logic              q_full;
  logic              q_empty;
  logic              wr_bank;
  logic              rd_bank;
  logic              mem_we;
  logic [PosW-1:0]   mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;
  logic [PosW-1:0]   rpos;
  logic              push;
  logic [PosW-1:0]   push_len;
  logic              push_has_cmd;
  logic              pop;
  logic [PosW-1:0]   head_len;
  logic              head_has_cmd;
  result_t           res;

  cfpd_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (s_axis_tvalid_i),
    .byte_ready_o   (s_axis_tready_o),
    .byte_i         (s_axis_tdata_i),
    .burst_end_i    (s_axis_tlast_i),
    .full_i         (q_full),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .push_o         (push),
    .push_len_o     (push_len),
    .push_has_cmd_o (push_has_cmd)
  );

  cfpd_fifo #(
    .W(PosW + 1)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .din_i     ({push_len, push_has_cmd}),
    .pop_i     (pop),
    .dout_o    ({head_len, head_has_cmd}),
    .full_o    (q_full),
    .empty_o   (q_empty),
    .wr_bank_o (wr_bank),
    .rd_bank_o (rd_bank)
  );

  cfpd_buf #(
    .AW(AddrW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({wr_bank, mem_waddr}),
    .wdata_i (mem_wdata),
    .raddr_i ({rd_bank, rpos}),
    .rdata_o (mem_rdata)
  );

  cfpd_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (!q_empty),
    .len_i        (head_len),
    .has_cmd_i    (head_has_cmd),
    .rdata_i      (mem_rdata),
    .rpos_o       (rpos),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  assign m_axis_tdata_o = res.value;
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

  `CFPD_ASSERT_IMPL(a_push_has_room, push, !q_full)
  `CFPD_ASSERT_IMPL(a_pop_has_frame, pop, !q_empty)
  `CFPD_ASSERT_IMPL(a_len_in_range, push, push_len <= Limit)
  `CFPD_ASSERT_NEXT(a_pop_frees_bank, pop && !push, !q_full)

endmodule
